// ----- rtl/ssqt_pkg.sv -----
package ssqt_pkg;

    localparam int DEPTH_DEFAULT     = 64;
    localparam int TIME_BITS_DEFAULT = 32;

    typedef struct packed {
        logic [31:0] arrival_time;
        logic [31:0] main_index;
        logic [15:0] major_index;
        logic [15:0] minor_index;
        logic        is_write;
        logic [31:0] req_size;
        logic [31:0] service_time;
        logic [31:0] to_device_time;
        logic [31:0] from_device_time;
        logic [31:0] initial_wait;
        logic        last_record;
    } in_word_t;

    typedef struct packed {
        logic [31:0] out_main_index;
        logic [15:0] out_major_index;
        logic [15:0] out_minor_index;
        logic        out_is_write;
        logic [31:0] out_size;
        logic [31:0] out_arrival;
        logic [31:0] out_service;
        logic [32:0] out_transfer;
        logic [31:0] out_wait;
        logic        overflow_flag;
        logic        last_result;
    } out_word_t;

    // One sorted record as it travels from the sorter to the timing stage.
    typedef struct packed {
        logic [31:0] arrival;
        logic [31:0] main_index;
        logic [15:0] major_index;
        logic [15:0] minor_index;
        logic        is_write;
        logic [31:0] size;
        logic [31:0] service;
        logic [31:0] to_dev;
        logic [31:0] from_dev;
        logic [31:0] init_wait;
        logic        dropped;
        logic        last;
    } rec_t;

    typedef enum logic [1:0] {
        SORT_LOAD,
        SORT_DRAIN
    } sort_state_t;

    // True if record a orders strictly after record b.
    function automatic logic rec_after(rec_t a, rec_t b);
        logic [95:0] ka;
        logic [95:0] kb;
        begin
            ka = {a.arrival, a.main_index, a.major_index, a.minor_index};
            kb = {b.arrival, b.main_index, b.major_index, b.minor_index};
            return ka > kb;
        end
    endfunction

endpackage

// ----- rtl/ssqt_sorter.sv -----
// Front part: insertion sorter chain. Each stored word is placed in its sorted
// position as it is accepted; after the last word the chain shifts out in order.
module ssqt_sorter #(
    parameter int DEPTH = ssqt_pkg::DEPTH_DEFAULT
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  ssqt_pkg::in_word_t s_data,
    output logic             q_valid,
    input  logic             q_ready,
    output ssqt_pkg::rec_t   q_data
);
    import ssqt_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    rec_t              cell_reg [DEPTH];
    logic [DEPTH-1:0]  full_reg;
    logic [CW-1:0]     count_reg;
    logic              drop_reg;
    sort_state_t       state_reg, state_next;
    rec_t              new_rec;
    logic [DEPTH-1:0]  after_vec;
    logic [DEPTH-1:0]  prev_after_vec;
    logic [DEPTH-1:0]  prev_full_vec;
    rec_t              prev_cell [DEPTH];
    rec_t              next_cell [DEPTH];
    logic              load_fire, drain_fire, store_ok;

    // Build the incoming record.
    always_comb begin
        new_rec.arrival     = s_data.arrival_time;
        new_rec.main_index  = s_data.main_index;
        new_rec.major_index = s_data.major_index;
        new_rec.minor_index = s_data.minor_index;
        new_rec.is_write    = s_data.is_write;
        new_rec.size        = s_data.req_size;
        new_rec.service     = s_data.service_time;
        new_rec.to_dev      = s_data.to_device_time;
        new_rec.from_dev    = s_data.from_device_time;
        new_rec.init_wait   = s_data.initial_wait;
        new_rec.dropped     = 1'b0;
        new_rec.last        = 1'b0;
    end

    assign s_ready    = (state_reg == SORT_LOAD);
    assign load_fire  = s_valid && s_ready;
    assign store_ok   = load_fire && (s_data.minor_index != '0) && !full_reg[DEPTH-1];
    assign drain_fire = q_valid && q_ready;

    // Each cell compares against the new record in parallel.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            after_vec[i] = full_reg[i] && rec_after(cell_reg[i], new_rec);
        end
    end

    // Neighbor views of each cell; the head sees the new record, the tail holds.
    assign prev_after_vec = {after_vec[DEPTH-2:0], 1'b0};
    assign prev_full_vec  = {full_reg[DEPTH-2:0], 1'b1};

    for (genvar g = 0; g < DEPTH; g++) begin : g_link
        if (g == 0) begin : g_head
            assign prev_cell[g] = new_rec;
        end else begin : g_body
            assign prev_cell[g] = cell_reg[g-1];
        end
        if (g == DEPTH - 1) begin : g_tail
            assign next_cell[g] = cell_reg[g];
        end else begin : g_mid
            assign next_cell[g] = cell_reg[g+1];
        end
    end

    // Head of chain feeds the queue; flags are stamped on the way out.
    always_comb begin
        q_data         = cell_reg[0];
        q_data.dropped = drop_reg;
        q_data.last    = (DEPTH == 1) ? 1'b1 : !full_reg[1];
    end
    assign q_valid = (state_reg == SORT_DRAIN) && full_reg[0];

    // Load/drain control.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            SORT_LOAD: begin
                if (load_fire && s_data.last_record &&
                    (store_ok || full_reg[0])) begin
                    state_next = SORT_DRAIN;
                end
            end
            SORT_DRAIN: begin
                if (drain_fire && q_data.last) begin
                    state_next = SORT_LOAD;
                end
            end
            default: state_next = SORT_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SORT_LOAD;
            full_reg  <= '0;
            count_reg <= '0;
            drop_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (store_ok) begin
                full_reg  <= {full_reg[DEPTH-2:0], 1'b1};
                count_reg <= count_reg + CW'(1);
            end
            if (load_fire && (s_data.minor_index != '0) && full_reg[DEPTH-1]) begin
                drop_reg <= 1'b1;
            end
            if (drain_fire) begin
                full_reg  <= {1'b0, full_reg[DEPTH-1:1]};
                count_reg <= count_reg - CW'(1);
                if (q_data.last) begin
                    drop_reg <= 1'b0;
                end
            end
            // An empty batch still clears the drop flag.
            if (load_fire && s_data.last_record && !store_ok && !full_reg[0]) begin
                drop_reg <= 1'b0;
            end
        end
    end

    // Cell data: insert by shifting later cells up, or shift down on drain.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < DEPTH; i++) begin
            if (store_ok) begin
                if (prev_after_vec[i]) begin
                    cell_reg[i] <= prev_cell[i];
                end else if (after_vec[i] || (!full_reg[i] && prev_full_vec[i])) begin
                    cell_reg[i] <= new_rec;
                end
            end else if (drain_fire) begin
                cell_reg[i] <= next_cell[i];
            end
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(full_reg ^ {full_reg[DEPTH-2:0], 1'b1}))
        else $error("sorter occupancy is not contiguous");
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == CW'($countones(full_reg)))
        else $error("sorter count disagrees with occupancy");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == SORT_DRAIN) |-> full_reg[0])
        else $error("drain state with empty chain");

endmodule

// ----- rtl/ssqt_fifo.sv -----
// Short queue between the sorter and the timing stage.
module ssqt_fifo #(
    parameter int N = 2
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           i_valid,
    output logic           i_ready,
    input  ssqt_pkg::rec_t i_data,
    output logic           o_valid,
    input  logic           o_ready,
    output ssqt_pkg::rec_t o_data
);
    import ssqt_pkg::*;

    localparam int AW = $clog2(N);

    rec_t          mem_reg [N];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;
    logic          wr, rd;

    assign i_ready = (cnt_reg != (AW+1)'(N));
    assign o_valid = (cnt_reg != '0);
    assign o_data  = mem_reg[rp_reg];
    assign wr = i_valid && i_ready;
    assign rd = o_valid && o_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr) wp_reg <= (wp_reg == AW'(N-1)) ? '0 : wp_reg + 1'b1;
            if (rd) rp_reg <= (rp_reg == AW'(N-1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(wr) - (AW+1)'(rd);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr) mem_reg[wp_reg] <= i_data;
    end

endmodule

// ----- rtl/ssqt_timer.sv -----
// Back part: device clock recurrence, one record per cycle into an output register unless the output stalls.
module ssqt_timer #(
    parameter int TIME_BITS = ssqt_pkg::TIME_BITS_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                i_valid,
    output logic                i_ready,
    input  ssqt_pkg::rec_t      i_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ssqt_pkg::out_word_t m_data
);
    import ssqt_pkg::*;

    localparam int WB = (TIME_BITS >= 32) ? 32 : TIME_BITS;
    localparam logic [40:0] LIM = (41'd1 << WB) - 41'd1;

    logic [39:0] clk_reg;
    logic        vld_reg;
    out_word_t   out_reg;
    logic [39:0] bus, start, delay;
    logic [40:0] wsum;
    logic        take;

    assign i_ready = !vld_reg || m_ready;
    assign take    = i_valid && i_ready;
    assign m_valid = vld_reg;
    assign m_data  = out_reg;

    // Lindley step.
    always_comb begin
        bus   = 40'(i_data.arrival) + 40'(i_data.to_dev);
        start = (clk_reg < bus) ? bus : clk_reg;
        delay = start - bus;
        wsum  = 41'(delay) + 41'(i_data.init_wait);
        if (wsum > LIM) wsum = LIM;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clk_reg <= '0;
            vld_reg <= 1'b0;
        end else begin
            if (take) begin
                clk_reg <= i_data.last ? '0 : start + 40'(i_data.service);
                vld_reg <= 1'b1;
            end else if (m_ready) begin
                vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            out_reg.out_main_index  <= i_data.main_index;
            out_reg.out_major_index <= i_data.major_index;
            out_reg.out_minor_index <= i_data.minor_index;
            out_reg.out_is_write    <= i_data.is_write;
            out_reg.out_size        <= i_data.size;
            out_reg.out_arrival     <= i_data.arrival;
            out_reg.out_service     <= i_data.service;
            out_reg.out_transfer    <= 33'(i_data.to_dev) + 33'(i_data.from_dev);
            out_reg.out_wait        <= wsum[31:0];
            out_reg.overflow_flag   <= i_data.dropped;
            out_reg.last_result     <= i_data.last;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (take && i_data.last) |=> (clk_reg == '0))
        else $error("device clock not cleared after batch");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result lost while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (41'(m_data.out_wait) <= LIM))
        else $error("wait above saturation limit");

endmodule

// ----- rtl/sorted_single_server_queue_timing_core.sv -----
// Loads request words, one per cycle while loading, into an insertion sorter
// chain of DEPTH cells; words with minor index zero are ignored and words
// beyond DEPTH are dropped and flagged. The word marked last_record ends the
// batch: the block then stops taking input and delivers one result per stored
// record, one per cycle unless the output stalls, through a two-entry queue
// and a timing stage that applies the single-server queue recurrence. Input
// resumes once the last result of the batch has left the sorter chain.
module sorted_single_server_queue_timing_core #(
    parameter int DEPTH     = ssqt_pkg::DEPTH_DEFAULT,
    parameter int TIME_BITS = ssqt_pkg::TIME_BITS_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ssqt_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ssqt_pkg::out_word_t m_data
);
    import ssqt_pkg::*;

    logic qa_valid, qa_ready, qb_valid, qb_ready;
    rec_t qa_data, qb_data;

    ssqt_sorter #(.DEPTH(DEPTH)) u_sorter (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data,
        .q_valid(qa_valid), .q_ready(qa_ready), .q_data(qa_data)
    );

    ssqt_fifo #(.N(2)) u_fifo (
        .aclk, .aresetn,
        .i_valid(qa_valid), .i_ready(qa_ready), .i_data(qa_data),
        .o_valid(qb_valid), .o_ready(qb_ready), .o_data(qb_data)
    );

    ssqt_timer #(.TIME_BITS(TIME_BITS)) u_timer (
        .aclk, .aresetn,
        .i_valid(qb_valid), .i_ready(qb_ready), .i_data(qb_data),
        .m_valid, .m_ready, .m_data
    );

endmodule

// ----- bench/sorted_single_server_queue_timing_core_test.sv -----
`timescale 1ns / 1ps

module sorted_single_server_queue_timing_core_test;
    import ssqt_pkg::*;

    localparam int DEPTH = DEPTH_DEFAULT;
    localparam int TIME_BITS = TIME_BITS_DEFAULT;
    localparam int WATCHDOG_LIMIT = 20000;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_word_t s_data;
    logic m_valid;
    logic m_ready;
    out_word_t m_data;

    sorted_single_server_queue_timing_core #(
        .DEPTH(DEPTH),
        .TIME_BITS(TIME_BITS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data)
    );

    // Predictor state: the batch held in sorted key order, plus the drop flag.
    in_word_t batch_store[$];
    logic batch_dropped;
    out_word_t expected_results[$];
    int error_count;
    int idle_cycles;
    bit stall_enable;
    bit gap_enable;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Insert one word into the sorted batch; equal keys go after older ones.
    task automatic batch_insert(input in_word_t w);
        int pos;
        logic [95:0] k_new;
        logic [95:0] k_old;
        begin
            k_new = {w.arrival_time, w.main_index, w.major_index, w.minor_index};
            pos = batch_store.size();
            while (pos > 0) begin
                k_old = {batch_store[pos-1].arrival_time, batch_store[pos-1].main_index,
                         batch_store[pos-1].major_index, batch_store[pos-1].minor_index};
                if (k_old > k_new) pos--;
                else break;
            end
            batch_store.insert(pos, w);
        end
    endtask

    // Add one word to the batch; on the last word, apply the single-server queue recurrence to the whole batch.
    task automatic queue_timing_predict(input in_word_t w);
        logic [39:0] dev_clock;
        logic [39:0] bus;
        logic [39:0] wt;
        logic [39:0] lim;
        out_word_t r;
        begin
            if (w.minor_index != 16'd0) begin
                if (batch_store.size() >= DEPTH) batch_dropped = 1'b1;
                else batch_insert(w);
            end
            if (w.last_record) begin
                lim = (TIME_BITS >= 32) ? 40'hFFFFFFFF : ((40'd1 << TIME_BITS) - 40'd1);
                dev_clock = '0;
                foreach (batch_store[k]) begin
                    bus = 40'(batch_store[k].arrival_time) + 40'(batch_store[k].to_device_time);
                    if (dev_clock < bus) dev_clock = bus;
                    wt = 40'(batch_store[k].initial_wait) + (dev_clock - bus);
                    if (wt > lim) wt = lim;
                    dev_clock += 40'(batch_store[k].service_time);
                    r.out_main_index = batch_store[k].main_index;
                    r.out_major_index = batch_store[k].major_index;
                    r.out_minor_index = batch_store[k].minor_index;
                    r.out_is_write = batch_store[k].is_write;
                    r.out_size = batch_store[k].req_size;
                    r.out_arrival = batch_store[k].arrival_time;
                    r.out_service = batch_store[k].service_time;
                    r.out_transfer = 33'(batch_store[k].to_device_time)
                                   + 33'(batch_store[k].from_device_time);
                    r.out_wait = wt[31:0];
                    r.overflow_flag = batch_dropped;
                    r.last_result = (k == batch_store.size() - 1);
                    expected_results.insert(expected_results.size(), r);
                end
                batch_store.delete();
                batch_dropped = 1'b0;
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [39:0] got,
                                   input logic [39:0] want);
        begin
            error_count++;
            $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        end
    endtask

    // Send one word: optional gap with valid low, then hold valid until accepted.
    // Valid stays high after acceptance until the next word or an idle period.
    task automatic send_word(input in_word_t w);
        int gap;
        begin
            gap = gap_enable ? $urandom_range(0, 15) : 0;
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            s_data <= w;
            s_valid <= 1'b1;
            @(posedge aclk);
            while (!s_ready) @(posedge aclk);
            queue_timing_predict(w);
            @(negedge aclk);
        end
    endtask

    // Result consumer and checker.
    initial begin
        out_word_t want;
        int stall;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            stall = stall_enable ? $urandom_range(0, 15) : 0;
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected word", m_data.out_main_index, '0);
            end else begin
                want = expected_results.pop_front();
                if (m_data.out_main_index !== want.out_main_index)
                    report_mismatch("main", m_data.out_main_index, want.out_main_index);
                if (m_data.out_major_index !== want.out_major_index)
                    report_mismatch("major", m_data.out_major_index, want.out_major_index);
                if (m_data.out_minor_index !== want.out_minor_index)
                    report_mismatch("minor", m_data.out_minor_index, want.out_minor_index);
                if (m_data.out_is_write !== want.out_is_write)
                    report_mismatch("is_write", m_data.out_is_write, want.out_is_write);
                if (m_data.out_size !== want.out_size)
                    report_mismatch("size", m_data.out_size, want.out_size);
                if (m_data.out_arrival !== want.out_arrival)
                    report_mismatch("arrival", m_data.out_arrival, want.out_arrival);
                if (m_data.out_service !== want.out_service)
                    report_mismatch("service", m_data.out_service, want.out_service);
                if (m_data.out_transfer !== want.out_transfer)
                    report_mismatch("transfer", m_data.out_transfer, want.out_transfer);
                if (m_data.out_wait !== want.out_wait)
                    report_mismatch("wait", m_data.out_wait, want.out_wait);
                if (m_data.overflow_flag !== want.overflow_flag)
                    report_mismatch("overflow", m_data.overflow_flag, want.overflow_flag);
                if (m_data.last_result !== want.last_result)
                    report_mismatch("last", m_data.last_result, want.last_result);
            end
        end
    end

    // Watchdog: count cycles without any accepted word.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic in_word_t random_word(input bit last, input int key_spread);
        in_word_t w;
        begin
            w.arrival_time = (key_spread == 0) ? $urandom() : $urandom_range(0, key_spread);
            w.main_index = (key_spread == 0) ? $urandom() : $urandom_range(0, 3);
            w.major_index = (key_spread == 0) ? 16'($urandom()) : 16'($urandom_range(0, 2));
            w.minor_index = (key_spread == 0) ? 16'($urandom()) : 16'($urandom_range(1, 2));
            w.is_write = 1'($urandom_range(0, 1));
            w.req_size = $urandom();
            w.service_time = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 4000);
            w.to_device_time = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 500);
            w.from_device_time = $urandom();
            w.initial_wait = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 1000);
            w.last_record = last;
            return w;
        end
    endfunction

    // Drop valid and wait until every expected result has been seen.
    task automatic wait_drained();
        begin
            s_valid <= 1'b0;
            while (expected_results.size() != 0) @(posedge aclk);
            repeat (4) @(negedge aclk);
        end
    endtask

    // Extremes, ignored words, empty batch, ignored last word, ties.
    task automatic test_directed();
        in_word_t w;
        begin
            w = '0;
            w.last_record = 1'b1;
            send_word(w);
            w = '1;
            w.last_record = 1'b0;
            send_word(w);
            w.minor_index = 16'd0;
            send_word(w);
            w = '0;
            w.minor_index = 16'd1;
            w.to_device_time = '1;
            w.from_device_time = '1;
            send_word(w);
            w.is_write = 1'b1;
            w.initial_wait = 32'hFFFF_FFF0;
            w.service_time = 32'hFFFF_FFFF;
            w.to_device_time = '0;
            send_word(w);
            send_word(w);
            w = '0;
            w.last_record = 1'b1;
            send_word(w);
            wait_drained();
        end
    endtask

    // Overflow: more than DEPTH qualifying words in one batch.
    task automatic test_overflow();
        begin
            for (int i = 0; i < DEPTH + 3; i++) send_word(random_word(i == DEPTH + 2, 50));
            wait_drained();
        end
    endtask

    // Random batches of mostly small size, sometimes with ignored words.
    task automatic test_random_batches();
        in_word_t w;
        int sent;
        int len;
        begin
            sent = 0;
            while (sent < 370) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, DEPTH)
                                                 : $urandom_range(1, 8);
                stall_enable = ($urandom_range(0, 3) != 0);
                gap_enable = ($urandom_range(0, 3) != 0);
                for (int i = 0; i < len; i++) begin
                    w = random_word(i == len - 1, ($urandom_range(0, 1) == 0) ? 0 : 30);
                    if ($urandom_range(0, 9) == 0) w.minor_index = 16'd0;
                    send_word(w);
                    sent++;
                end
            end
            wait_drained();
        end
    endtask

    initial begin
        error_count = 0;
        idle_cycles = 0;
        batch_dropped = 1'b0;
        stall_enable = 1'b1;
        gap_enable = 1'b1;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_overflow();
        test_random_batches();
        repeat (20) @(posedge aclk);
        if (error_count == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

endmodule
